[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the tokenizer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

[rtl/sept_pkg.sv]
// ----------------------------------------------------------------------------
// sept_pkg
// Types, character constants and separator codes for the separator tokenizer.
// ----------------------------------------------------------------------------
package sept_pkg;

    // Separator codes
    localparam logic [4:0] CODE_NONE        = 5'd0;
    localparam logic [4:0] CODE_CRLF        = 5'd1;
    localparam logic [4:0] CODE_SLASH2      = 5'd2;
    localparam logic [4:0] CODE_COMMENT     = 5'd3;
    localparam logic [4:0] CODE_SINGLE_BASE = 5'd4;

    // Characters of interest
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;

    localparam logic [15:0] CNT_MAX = 16'hFFFF;

    // Result queue depth
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

    // One result item
    typedef struct packed {
        logic [15:0] token_start;
        logic [15:0] token_length;
        logic [4:0]  separator_code;
        logic [15:0] line_count;
        logic        end_token;
    } t_result;

    // Everything one byte produces: a separator token and/or the closing token
    typedef struct packed {
        logic    tok_valid;
        t_result tok;
        logic    close_valid;
        t_result close;
    } t_entry;

    // Queue status seen by the front, the back and the top level
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    // Single-byte separator lookup, 0 when the byte is not one
    function automatic logic [4:0] single_code(input logic [7:0] b);
        logic [4:0] code;
        unique case (b)
            8'd10:  code = CODE_SINGLE_BASE + 5'd0;
            8'd9:   code = CODE_SINGLE_BASE + 5'd1;
            8'd32:  code = CODE_SINGLE_BASE + 5'd2;
            8'h2E:  code = CODE_SINGLE_BASE + 5'd3;   // .
            8'h2C:  code = CODE_SINGLE_BASE + 5'd4;   // ,
            8'h3A:  code = CODE_SINGLE_BASE + 5'd5;   // :
            8'h3B:  code = CODE_SINGLE_BASE + 5'd6;   // ;
            8'h2B:  code = CODE_SINGLE_BASE + 5'd7;   // +
            8'h2D:  code = CODE_SINGLE_BASE + 5'd8;   // -
            8'h28:  code = CODE_SINGLE_BASE + 5'd9;   // (
            8'h29:  code = CODE_SINGLE_BASE + 5'd10;  // )
            8'h21:  code = CODE_SINGLE_BASE + 5'd11;  // !
            8'h3D:  code = CODE_SINGLE_BASE + 5'd12;  // =
            8'h26:  code = CODE_SINGLE_BASE + 5'd13;  // &
            8'h25:  code = CODE_SINGLE_BASE + 5'd14;  // %
            8'h2A:  code = CODE_SINGLE_BASE + 5'd15;  // *
            8'h3C:  code = CODE_SINGLE_BASE + 5'd16;  // <
            8'h3E:  code = CODE_SINGLE_BASE + 5'd17;  // >
            8'h5B:  code = CODE_SINGLE_BASE + 5'd18;  // [
            8'h5D:  code = CODE_SINGLE_BASE + 5'd19;  // ]
            8'h7B:  code = CODE_SINGLE_BASE + 5'd20;  // {
            8'h7D:  code = CODE_SINGLE_BASE + 5'd21;  // }
            default: code = CODE_NONE;
        endcase
        return code;
    endfunction

    // Saturating 16-bit increment
    function automatic logic [15:0] sat_inc16(input logic [15:0] v);
        return (v == CNT_MAX) ? v : v + 16'd1;
    endfunction

endpackage

[rtl/sept_front.sv]
// ----------------------------------------------------------------------------
// sept_front
// Accepts text bytes, classifies them and advances the tokenizer state;
// builds the result entry each byte produces.
// ----------------------------------------------------------------------------
module sept_front #(
    parameter int OFFSET_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [7:0]       i_data,
    input  logic             i_last,
    output logic             o_ready,
    input  sept_pkg::t_queue_status i_queue_status,
    output logic             o_push,
    output sept_pkg::t_entry o_entry
);
    import sept_pkg::*;

    localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

    logic [7:0]             r_held_byte,   n_held_byte;
    logic                   r_held_valid,  n_held_valid;
    logic                   r_skipping,    n_skipping;
    logic [OFFSET_BITS-1:0] r_start,       n_start;
    logic [15:0]            r_run,         n_run;
    logic [OFFSET_BITS-1:0] r_pos,         n_pos;
    logic [15:0]            r_newline,     n_newline;

    logic                   accept;
    logic [OFFSET_BITS-1:0] pos_next;
    logic [15:0]            nl_next;
    logic [4:0]             pair_code;
    logic                   pair_hit;
    logic                   skip1;
    logic [15:0]            run1;
    logic                   is_ws;
    logic [4:0]             sc;
    logic [OFFSET_BITS-1:0] st;
    logic [15:0]            rn;
    logic                   skip2;
    logic [OFFSET_BITS-1:0] start2;
    logic [15:0]            run2;
    logic                   heldv2;
    logic [7:0]             heldb2;
    logic                   tok_emit;
    logic [4:0]             tok_code;
    logic [OFFSET_BITS-1:0] tok_start;
    logic [15:0]            tok_len;

    // Hold off transfers while in reset or while the queue is full
    assign o_ready = i_rst_n && !i_queue_status.full;
    assign accept  = i_valid && o_ready;

    // Position and newline counters
    assign pos_next = (r_pos == POS_MAX) ? r_pos : r_pos + OFFSET_BITS'(1);
    assign nl_next  = (i_data == CH_LF) ? sat_inc16(r_newline) : r_newline;

    // Complete a held two-byte separator
    always_comb begin
        pair_code = CODE_NONE;
        if (r_held_valid) begin
            if (r_held_byte == CH_CR && i_data == CH_LF) begin
                pair_code = CODE_CRLF;
            end else if (r_held_byte == CH_SLASH && i_data == CH_SLASH) begin
                pair_code = CODE_SLASH2;
            end else if (r_held_byte == CH_SLASH && i_data == CH_STAR) begin
                pair_code = CODE_COMMENT;
            end
        end
    end

    assign pair_hit = (pair_code != CODE_NONE);
    // A held byte that does not pair up becomes a token byte
    assign skip1 = pair_hit ? 1'b1 : r_skipping;
    assign run1  = pair_hit ? 16'd0 :
                   (r_held_valid ? sat_inc16(r_run) : r_run);

    assign is_ws = (i_data >= CH_TAB && i_data <= CH_CR) || (i_data == CH_SPACE);
    assign sc    = single_code(i_data);
    assign st    = skip1 ? r_pos : r_start;
    assign rn    = skip1 ? 16'd0 : run1;

    // Take the current byte unless the pair consumed it
    always_comb begin
        skip2     = skip1;
        start2    = r_start;
        run2      = run1;
        heldv2    = 1'b0;
        heldb2    = r_held_byte;
        tok_emit  = pair_hit;
        tok_code  = pair_code;
        tok_start = r_start;
        tok_len   = r_run;
        if (!pair_hit && !(skip1 && is_ws)) begin
            skip2  = 1'b0;
            start2 = st;
            run2   = rn;
            if ((i_data == CH_CR || i_data == CH_SLASH) && !i_last) begin
                heldv2 = 1'b1;
                heldb2 = i_data;
            end else if (sc != CODE_NONE) begin
                if (rn == 16'd0) begin
                    start2 = pos_next;
                end else begin
                    tok_emit  = 1'b1;
                    tok_code  = sc;
                    tok_start = st;
                    tok_len   = rn;
                    skip2     = 1'b1;
                    run2      = 16'd0;
                end
            end else begin
                run2 = sat_inc16(rn);
            end
        end
    end

    // Build the entry for the queue
    always_comb begin
        o_entry.tok_valid            = tok_emit;
        o_entry.tok.token_start      = 16'(tok_start);
        o_entry.tok.token_length     = tok_len;
        o_entry.tok.separator_code   = tok_code;
        o_entry.tok.line_count       = nl_next;
        o_entry.tok.end_token        = 1'b0;
        o_entry.close_valid          = i_last;
        o_entry.close.token_start    = 16'(skip2 ? pos_next : start2);
        o_entry.close.token_length   = run2;
        o_entry.close.separator_code = CODE_NONE;
        o_entry.close.line_count     = nl_next;
        o_entry.close.end_token      = 1'b1;
    end

    assign o_push = accept && (tok_emit || i_last);

    // Next state: return to reset values after the final byte
    always_comb begin
        n_held_byte  = r_held_byte;
        n_held_valid = r_held_valid;
        n_skipping   = r_skipping;
        n_start      = r_start;
        n_run        = r_run;
        n_pos        = r_pos;
        n_newline    = r_newline;
        if (accept) begin
            if (i_last) begin
                n_held_byte  = 8'd0;
                n_held_valid = 1'b0;
                n_skipping   = 1'b1;
                n_start      = '0;
                n_run        = 16'd0;
                n_pos        = '0;
                n_newline    = 16'd0;
            end else begin
                n_held_byte  = heldb2;
                n_held_valid = heldv2;
                n_skipping   = skip2;
                n_start      = start2;
                n_run        = run2;
                n_pos        = pos_next;
                n_newline    = nl_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_byte  <= 8'd0;
            r_held_valid <= 1'b0;
            r_skipping   <= 1'b1;
            r_start      <= '0;
            r_run        <= 16'd0;
            r_pos        <= '0;
            r_newline    <= 16'd0;
        end else begin
            r_held_byte  <= n_held_byte;
            r_held_valid <= n_held_valid;
            r_skipping   <= n_skipping;
            r_start      <= n_start;
            r_run        <= n_run;
            r_pos        <= n_pos;
            r_newline    <= n_newline;
        end
    end

endmodule

[rtl/sept_queue.sv]
// ----------------------------------------------------------------------------
// sept_queue
// Short register queue of result entries between the front and back parts.
// ----------------------------------------------------------------------------
module sept_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  sept_pkg::t_entry        i_entry,
    input  logic                    i_pop,
    output sept_pkg::t_entry        o_head,
    output sept_pkg::t_queue_status o_status
);
    import sept_pkg::*;

    localparam logic [QUEUE_PTR_BITS:0] COUNT_FULL = (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH);
    localparam logic [QUEUE_PTR_BITS-1:0] PTR_LAST = QUEUE_PTR_BITS'(QUEUE_DEPTH - 1);

    t_entry                    r_slot [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_PTR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_PTR_BITS:0]   r_count,  n_count;
    logic                      do_push;
    logic                      do_pop;

    assign o_status.full  = (r_count == COUNT_FULL);
    assign o_status.empty = (r_count == '0);
    assign o_head         = r_slot[r_rd_ptr];

    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;

    // Advance pointers and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + QUEUE_PTR_BITS'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + QUEUE_PTR_BITS'(1);
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + (QUEUE_PTR_BITS + 1)'(1);
            2'b01:   n_count = r_count - (QUEUE_PTR_BITS + 1)'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Write the slot, payload needs no reset
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

endmodule

[rtl/sept_back.sv]
// ----------------------------------------------------------------------------
// sept_back
// Unpacks queued entries into single result transfers through an output
// register on the master stream.
// ----------------------------------------------------------------------------
module sept_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  sept_pkg::t_entry        i_head,
    input  sept_pkg::t_queue_status i_queue_status,
    output logic                    o_pop,
    output logic                    o_valid,
    input  logic                    i_ready,
    output sept_pkg::t_result       o_result
);
    import sept_pkg::*;

    logic    r_phase, n_phase;
    logic    r_valid, n_valid;
    t_result r_result, n_result;
    logic    load;
    logic    use_close;

    assign load      = !r_valid || i_ready;
    // Second half of an entry, or an entry with only the closing token
    assign use_close = r_phase || !i_head.tok_valid;

    always_comb begin
        n_phase  = r_phase;
        n_valid  = r_valid;
        n_result = r_result;
        o_pop    = 1'b0;
        if (load) begin
            n_valid = !i_queue_status.empty;
            if (!i_queue_status.empty) begin
                n_result = use_close ? i_head.close : i_head.tok;
                o_pop    = use_close || !i_head.close_valid;
                n_phase  = !(use_close || !i_head.close_valid);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_valid <= n_valid;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

[rtl/separator_tokenizer.sv]
// ----------------------------------------------------------------------------
// separator_tokenizer
// Splits a text byte stream into tokens ended by separators.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one text byte per transfer in tdata, tlast on the final byte
//   of a buffer. Master stream: one token per transfer; tlast marks the
//   closing token that every buffer ends with.
//   The front accepts one byte per cycle whenever the four-entry result queue
//   has room; tready does not depend on the byte itself. A byte yields zero,
//   one or two tokens (a separator token and, on the final byte, the closing
//   token). A token is written into the result queue and then into the output
//   register before it is presented on the master side. Throughput is one byte
//   per cycle while the queue has room; a separator token and the closing token
//   from the same byte leave the output register one after the other, the
//   separator token first. When the receiver stalls the output register holds
//   its token, the queue fills, and tready falls once all four queue entries are
//   taken. Reset clears the tokenizer state, the queue pointers and the output
//   valid flag, not the token payload; tready is high as soon as reset is released.
//   After the final byte of a buffer the state returns to its reset values.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module separator_tokenizer #(
    parameter int OFFSET_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata,   // [15:0] token_start, [31:16] token_length,
                                     // [36:32] separator_code, [52:37] line_count
    output logic        o_m_tlast
);
    import sept_pkg::*;

    logic          w_push;
    logic          w_pop;
    t_entry        w_entry;
    t_entry        w_head;
    t_queue_status w_status;
    t_result       w_result;

    // Classify bytes and advance tokenizer state
    sept_front #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_s_tvalid),
        .i_data         (i_s_tdata),
        .i_last         (i_s_tlast),
        .o_ready        (o_s_tready),
        .i_queue_status (w_status),
        .o_push         (w_push),
        .o_entry        (w_entry)
    );

    // Decouple the two sides
    sept_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_entry  (w_entry),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_status)
    );

    // Deliver tokens one transfer at a time
    sept_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (w_head),
        .i_queue_status (w_status),
        .o_pop          (w_pop),
        .o_valid        (o_m_tvalid),
        .i_ready        (i_m_tready),
        .o_result       (w_result)
    );

    assign o_m_tdata = {3'b000, w_result.line_count, w_result.separator_code,
                        w_result.token_length, w_result.token_start};
    assign o_m_tlast = w_result.end_token;

    // Checks
    `ASSERT_IMPLIES(a_no_push_when_full, i_clk, i_rst_n, w_push, !w_status.full)
    `ASSERT_IMPLIES(a_close_has_no_sep, i_clk, i_rst_n, o_m_tvalid && o_m_tlast,
        w_result.separator_code == CODE_NONE)
    `ASSERT_IMPLIES(a_token_has_sep, i_clk, i_rst_n, o_m_tvalid && !o_m_tlast,
        w_result.separator_code != CODE_NONE)
    `ASSERT_NEXT(a_push_reaches_output, i_clk, i_rst_n, w_push && w_status.empty,
        !w_status.empty || o_m_tvalid)

endmodule
